>>> design/treyfer_hash_compress_defines.svh
// Assertion macros shared by the treyfer hash compression RTL.
`ifndef TREYFER_HASH_COMPRESS_DEFINES_SVH
`define TREYFER_HASH_COMPRESS_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define THC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define THC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/thc_pkg.sv
// Shared types, constants and the substitution table of the treyfer hash compression block.
package thc_pkg;

    // Byte lanes in one 64-bit word.
    localparam int LANES = 8;

    // Control of the digest store for one cycle.
    typedef struct packed {
        logic             clear;
        logic [LANES-1:0] wr_lanes;
    } dig_ctrl_t;

    // Fixed 8-bit substitution, a permutation derived from the bits of pi.
    localparam logic [7:0] SBOX [256] = '{
        8'd113, 8'd191, 8'd44,  8'd197, 8'd147, 8'd25,  8'd97,  8'd189,
        8'd71,  8'd99,  8'd232, 8'd142, 8'd227, 8'd110, 8'd144, 8'd104,
        8'd21,  8'd129, 8'd39,  8'd201, 8'd11,  8'd198, 8'd208, 8'd5,
        8'd135, 8'd88,  8'd162, 8'd79,  8'd216, 8'd183, 8'd205, 8'd119,
        8'd40,  8'd74,  8'd63,  8'd160, 8'd84,  8'd164, 8'd73,  8'd13,
        8'd245, 8'd206, 8'd52,  8'd217, 8'd22,  8'd235, 8'd165, 8'd28,
        8'd152, 8'd17,  8'd3,   8'd106, 8'd128, 8'd90,  8'd170, 8'd120,
        8'd167, 8'd240, 8'd154, 8'd150, 8'd59,  8'd108, 8'd109, 8'd70,
        8'd242, 8'd66,  8'd149, 8'd1,   8'd93,  8'd236, 8'd19,  8'd234,
        8'd117, 8'd237, 8'd221, 8'd111, 8'd228, 8'd55,  8'd246, 8'd6,
        8'd75,  8'd47,  8'd174, 8'd91,  8'd72,  8'd2,   8'd27,  8'd78,
        8'd32,  8'd29,  8'd141, 8'd253, 8'd115, 8'd254, 8'd33,  8'd210,
        8'd215, 8'd181, 8'd42,  8'd98,  8'd185, 8'd172, 8'd143, 8'd35,
        8'd199, 8'd4,   8'd153, 8'd247, 8'd87,  8'd121, 8'd157, 8'd158,
        8'd62,  8'd100, 8'd118, 8'd173, 8'd50,  8'd220, 8'd196, 8'd130,
        8'd61,  8'd80,  8'd15,  8'd77,  8'd14,  8'd95,  8'd132, 8'd30,
        8'd249, 8'd139, 8'd244, 8'd155, 8'd233, 8'd8,   8'd103, 8'd175,
        8'd231, 8'd178, 8'd224, 8'd64,  8'd96,  8'd255, 8'd86,  8'd203,
        8'd250, 8'd68,  8'd114, 8'd136, 8'd23,  8'd218, 8'd67,  8'd51,
        8'd94,  8'd156, 8'd148, 8'd212, 8'd184, 8'd116, 8'd45,  8'd138,
        8'd179, 8'd243, 8'd37,  8'd56,  8'd200, 8'd207, 8'd12,  8'd38,
        8'd204, 8'd186, 8'd159, 8'd34,  8'd213, 8'd192, 8'd41,  8'd0,
        8'd180, 8'd122, 8'd20,  8'd60,  8'd58,  8'd222, 8'd134, 8'd137,
        8'd241, 8'd112, 8'd182, 8'd169, 8'd92,  8'd26,  8'd219, 8'd24,
        8'd127, 8'd194, 8'd171, 8'd209, 8'd7,   8'd85,  8'd195, 8'd9,
        8'd65,  8'd226, 8'd43,  8'd248, 8'd83,  8'd211, 8'd202, 8'd190,
        8'd239, 8'd10,  8'd229, 8'd251, 8'd102, 8'd76,  8'd57,  8'd238,
        8'd89,  8'd105, 8'd101, 8'd187, 8'd177, 8'd131, 8'd123, 8'd225,
        8'd82,  8'd126, 8'd16,  8'd188, 8'd166, 8'd140, 8'd163, 8'd193,
        8'd49,  8'd48,  8'd36,  8'd18,  8'd53,  8'd81,  8'd146, 8'd252,
        8'd69,  8'd54,  8'd31,  8'd161, 8'd145, 8'd107, 8'd168, 8'd176,
        8'd46,  8'd125, 8'd124, 8'd223, 8'd230, 8'd214, 8'd151, 8'd133
    };

endpackage

>>> design/thc_digest_store.sv
// Digest memory with byte-lane writes and per-byte valid flags that read unwritten bytes as zero.
module thc_digest_store #(
    parameter int WORDS = 8,
    parameter int ROW_W = 3
) (
    input  logic                clk,
    input  logic                rst_n,
    input  thc_pkg::dig_ctrl_t  ctrl,
    input  logic [ROW_W-1:0]    rd_row,
    input  logic [ROW_W-1:0]    wr_row,
    input  logic [63:0]         wr_data,
    output logic [63:0]         rd_data
);

    logic [63:0]                   mem [WORDS];
    logic [thc_pkg::LANES-1:0]     valid_reg [WORDS];
    logic [63:0]                   rd_data_reg;
    logic [thc_pkg::LANES-1:0]     rd_valid_reg;

    // Storage and the registered read port.
    always_ff @(posedge clk)
    begin
        for (int l = 0; l < thc_pkg::LANES; l++)
        begin
            if (ctrl.wr_lanes[l])
            begin
                mem[wr_row][l*8 +: 8] <= wr_data[l*8 +: 8];
            end
        end
        rd_data_reg  <= mem[rd_row];
        rd_valid_reg <= valid_reg[rd_row];
    end

    // A clear drops every flag at once, so the whole digest reads as zero afterwards.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < WORDS; r++)
            begin
                valid_reg[r] <= '0;
            end
        end
        else if (ctrl.clear)
        begin
            for (int r = 0; r < WORDS; r++)
            begin
                valid_reg[r] <= '0;
            end
        end
        else
        begin
            valid_reg[wr_row] <= valid_reg[wr_row] | ctrl.wr_lanes;
        end
    end

    always_comb
    begin
        for (int l = 0; l < thc_pkg::LANES; l++)
        begin
            rd_data[l*8 +: 8] = rd_valid_reg[l] ? rd_data_reg[l*8 +: 8] : 8'h00;
        end
    end

endmodule

>>> design/treyfer_hash_compress.sv
// Top level of the treyfer hash compression block: control, block buffer and mixing datapath.
//
// The block folds message blocks of BLOCK_BYTES bytes into a digest of the same size.
// A word is offered on block_word with start high; it is taken at a rising edge where busy
// is low. start_fresh on a beat clears the digest to zero before that word is used; on a
// later word of a block it still clears the digest while the block carries on.
// Words that are not a block's last are buffered and busy stays low.
// The last word of a block starts compression: busy rises and stays high through the
// mixing loop and the sweep. The mixing loop runs one step per cycle through the single
// read and write port of the digest memory, and that serial chain of steps sets the rate.
// The digest is then XORed with the buffered block one word per cycle, and each word is
// presented on digest_word for one cycle with done high, word_number counting from zero and
// digest_last high on the final beat. Results come out on consecutive cycles; the receiver
// cannot stall them and must take each beat as it appears.
// Reset clears the control state and marks the whole digest as zero; the block buffer holds
// no meaningful data until a block has been written into it.
`include "treyfer_hash_compress_defines.svh"

module treyfer_hash_compress #(
    parameter int BLOCK_BYTES = 64,
    parameter int ROUNDS      = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] block_word,
    input  logic        start_fresh,
    output logic        done,
    output logic [63:0] digest_word,
    output logic [2:0]  word_number,
    output logic        digest_last
);

    localparam int WORDS       = (BLOCK_BYTES + 7) / 8;
    localparam int ROW_W       = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int SW_W        = $clog2(WORDS + 1);
    localparam int TOTAL_STEPS = 8 * ROUNDS;
    localparam int STEP_W      = $clog2(TOTAL_STEPS);

    localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(WORDS - 1);
    localparam logic [2:0]        LAST_LANE = 3'((BLOCK_BYTES - 1) % 8);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(TOTAL_STEPS - 1);
    localparam logic [SW_W-1:0]   SW_END    = SW_W'(WORDS);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_PRIME = 5'b00010,
        ST_LOAD  = 5'b00100,
        ST_MIX   = 5'b01000,
        ST_SWEEP = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [ROW_W-1:0]    word_pos_reg, word_pos_next;
    logic [ROW_W-1:0]    cur_row_reg, cur_row_next;
    logic [2:0]          cur_lane_reg, cur_lane_next;
    logic [7:0]          acc_reg, acc_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [SW_W-1:0]     sw_reg, sw_next;
    logic [ROW_W-1:0]    sw_row_reg;
    logic                done_reg, done_next;
    logic [63:0]         digest_word_reg;
    logic [2:0]          word_number_reg;
    logic                digest_last_reg;

    logic                accept;
    logic [ROW_W-1:0]    nxt_row;
    logic [2:0]          nxt_lane;
    logic [ROW_W-1:0]    rd_row;
    logic [ROW_W-1:0]    wr_row;
    logic [63:0]         wr_data;
    logic [63:0]         dig_rd;
    logic [63:0]         blk_rd_reg;
    logic [63:0]         blk_mem [WORDS];
    logic [7:0]          mix_in;
    logic [7:0]          mix_sum;
    logic [7:0]          mix_out;
    logic [7:0]          sweep_mask;
    logic [63:0]         sweep_word;
    logic                sweep_emit;
    thc_pkg::dig_ctrl_t  dig_ctrl;

    assign accept     = start && (state_reg == ST_IDLE);
    assign busy       = (state_reg != ST_IDLE);
    assign sweep_emit = (state_reg == ST_SWEEP) && (sw_reg != '0);

    // Byte index that follows the current one, wrapping at the end of the block.
    always_comb
    begin
        if ((cur_row_reg == LAST_ROW) && (cur_lane_reg == LAST_LANE))
        begin
            nxt_row  = '0;
            nxt_lane = '0;
        end
        else if (cur_lane_reg == 3'd7)
        begin
            nxt_row  = cur_row_reg + ROW_W'(1);
            nxt_lane = '0;
        end
        else
        begin
            nxt_row  = cur_row_reg;
            nxt_lane = cur_lane_reg + 3'd1;
        end
    end

    // One mixing step: substitute the running byte, add the digest byte, rotate left by one.
    assign mix_in  = dig_rd[cur_lane_reg*8 +: 8];
    assign mix_sum = thc_pkg::SBOX[acc_reg] + mix_in;
    assign mix_out = {mix_sum[6:0], mix_sum[7]};

    // Lanes of the row being swept that lie inside the block.
    always_comb
    begin
        for (int l = 0; l < thc_pkg::LANES; l++)
        begin
            sweep_mask[l] = (sw_row_reg != LAST_ROW) || (3'(l) <= LAST_LANE);
        end
        for (int l = 0; l < thc_pkg::LANES; l++)
        begin
            sweep_word[l*8 +: 8] = sweep_mask[l] ? (dig_rd[l*8 +: 8] ^ blk_rd_reg[l*8 +: 8])
                                                 : 8'h00;
        end
    end

    // Read address of both memories. During mixing the next byte is fetched ahead through the
    // registered read, so the row in dig_rd always holds the byte that the current step consumes.
    always_comb
    begin
        rd_row = '0;
        unique case (state_reg)
            ST_LOAD, ST_MIX:
            begin
                rd_row = nxt_row;
            end
            ST_SWEEP:
            begin
                rd_row = (sw_reg == SW_END) ? '0 : sw_reg[ROW_W-1:0];
            end
            default:
            begin
                rd_row = '0;
            end
        endcase
    end

    // Write side of the digest store.
    always_comb
    begin
        dig_ctrl.clear    = accept && start_fresh;
        dig_ctrl.wr_lanes = '0;
        wr_row            = cur_row_reg;
        wr_data           = {thc_pkg::LANES{mix_out}};
        if (state_reg == ST_MIX)
        begin
            dig_ctrl.wr_lanes = thc_pkg::LANES'(1) << cur_lane_reg;
        end
        else if (sweep_emit)
        begin
            dig_ctrl.wr_lanes = sweep_mask;
            wr_row            = sw_row_reg;
            wr_data           = sweep_word;
        end
    end

    thc_digest_store #(
        .WORDS (WORDS),
        .ROW_W (ROW_W)
    ) u_digest (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (dig_ctrl),
        .rd_row  (rd_row),
        .wr_row  (wr_row),
        .wr_data (wr_data),
        .rd_data (dig_rd)
    );

    // Block buffer: written one word per accepted beat, read during the sweep.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            blk_mem[word_pos_reg] <= block_word;
        end
        blk_rd_reg <= blk_mem[rd_row];
    end

    // Sequencer.
    always_comb
    begin
        state_next    = state_reg;
        word_pos_next = word_pos_reg;
        cur_row_next  = cur_row_reg;
        cur_lane_next = cur_lane_reg;
        acc_next      = acc_reg;
        step_next     = step_reg;
        sw_next       = sw_reg;
        done_next     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (word_pos_reg == LAST_ROW)
                    begin
                        word_pos_next = '0;
                        state_next    = ST_PRIME;
                    end
                    else
                    begin
                        word_pos_next = word_pos_reg + ROW_W'(1);
                    end
                end
            end
            ST_PRIME:
            begin
                // Row zero is being read; the running byte starts from digest byte zero.
                cur_row_next  = '0;
                cur_lane_next = '0;
                state_next    = ST_LOAD;
            end
            ST_LOAD:
            begin
                acc_next      = dig_rd[7:0];
                cur_row_next  = nxt_row;
                cur_lane_next = nxt_lane;
                step_next     = '0;
                state_next    = ST_MIX;
            end
            ST_MIX:
            begin
                acc_next      = mix_out;
                cur_row_next  = nxt_row;
                cur_lane_next = nxt_lane;
                if (step_reg == LAST_STEP)
                begin
                    step_next  = '0;
                    sw_next    = '0;
                    state_next = ST_SWEEP;
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            ST_SWEEP:
            begin
                done_next = sweep_emit;
                if (sw_reg == SW_END)
                begin
                    sw_next    = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    sw_next = sw_reg + SW_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            word_pos_reg <= '0;
            cur_row_reg  <= '0;
            cur_lane_reg <= '0;
            acc_reg      <= '0;
            step_reg     <= '0;
            sw_reg       <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            word_pos_reg <= word_pos_next;
            cur_row_reg  <= cur_row_next;
            cur_lane_reg <= cur_lane_next;
            acc_reg      <= acc_next;
            step_reg     <= step_next;
            sw_reg       <= sw_next;
            done_reg     <= done_next;
        end
    end

    // Result registers; sw_row_reg remembers which row the memories are returning.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SWEEP)
        begin
            sw_row_reg <= rd_row;
        end
        if (sweep_emit)
        begin
            digest_word_reg <= sweep_word;
            word_number_reg <= 3'(sw_row_reg);
            digest_last_reg <= (sw_row_reg == LAST_ROW);
        end
    end

    assign done        = done_reg;
    assign digest_word = digest_word_reg;
    assign word_number = word_number_reg;
    assign digest_last = digest_last_reg;

    `THC_ASSERT_IMPL(a_done_from_sweep, done_reg, $past(state_reg == ST_SWEEP), "result beat outside the sweep")
    `THC_ASSERT_NEXT(a_last_ends_burst, done_reg && digest_last_reg, !done_reg, "beat after the final digest word")
    `THC_ASSERT_NEXT(a_last_word_starts, accept && (word_pos_reg == LAST_ROW), state_reg == ST_PRIME, "last word did not start compression")
    `THC_ASSERT_IMPL(a_step_idle_zero, state_reg != ST_MIX, step_reg == '0, "step counter nonzero outside mixing")
    `THC_ASSERT_IMPL(a_mix_no_overlap, state_reg == ST_MIX, (nxt_row != cur_row_reg) || (nxt_lane != cur_lane_reg), "mixing read and write hit the same byte")

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the treyfer hash compression block.
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    // A generous bound on the whole run, which sends 27 blocks plus the sender's gaps.
    localparam int CYCLE_LIMIT  = 400_000;
    localparam int DRAIN_CYCLES = 24;
    localparam int WORDS        = 8;
    localparam int DIGEST_BYTES = 64;
    localparam int MIX_STEPS    = 2048;
    localparam int RANDOM_BLOCKS = 24;

    // The mixing permutation, kept here independently of the RTL package so that a slip in
    // the design's table shows up as a digest mismatch.
    localparam logic [7:0] MIX_SBOX [256] = '{
        8'd113, 8'd191, 8'd44,  8'd197, 8'd147, 8'd25,  8'd97,  8'd189,
        8'd71,  8'd99,  8'd232, 8'd142, 8'd227, 8'd110, 8'd144, 8'd104,
        8'd21,  8'd129, 8'd39,  8'd201, 8'd11,  8'd198, 8'd208, 8'd5,
        8'd135, 8'd88,  8'd162, 8'd79,  8'd216, 8'd183, 8'd205, 8'd119,
        8'd40,  8'd74,  8'd63,  8'd160, 8'd84,  8'd164, 8'd73,  8'd13,
        8'd245, 8'd206, 8'd52,  8'd217, 8'd22,  8'd235, 8'd165, 8'd28,
        8'd152, 8'd17,  8'd3,   8'd106, 8'd128, 8'd90,  8'd170, 8'd120,
        8'd167, 8'd240, 8'd154, 8'd150, 8'd59,  8'd108, 8'd109, 8'd70,
        8'd242, 8'd66,  8'd149, 8'd1,   8'd93,  8'd236, 8'd19,  8'd234,
        8'd117, 8'd237, 8'd221, 8'd111, 8'd228, 8'd55,  8'd246, 8'd6,
        8'd75,  8'd47,  8'd174, 8'd91,  8'd72,  8'd2,   8'd27,  8'd78,
        8'd32,  8'd29,  8'd141, 8'd253, 8'd115, 8'd254, 8'd33,  8'd210,
        8'd215, 8'd181, 8'd42,  8'd98,  8'd185, 8'd172, 8'd143, 8'd35,
        8'd199, 8'd4,   8'd153, 8'd247, 8'd87,  8'd121, 8'd157, 8'd158,
        8'd62,  8'd100, 8'd118, 8'd173, 8'd50,  8'd220, 8'd196, 8'd130,
        8'd61,  8'd80,  8'd15,  8'd77,  8'd14,  8'd95,  8'd132, 8'd30,
        8'd249, 8'd139, 8'd244, 8'd155, 8'd233, 8'd8,   8'd103, 8'd175,
        8'd231, 8'd178, 8'd224, 8'd64,  8'd96,  8'd255, 8'd86,  8'd203,
        8'd250, 8'd68,  8'd114, 8'd136, 8'd23,  8'd218, 8'd67,  8'd51,
        8'd94,  8'd156, 8'd148, 8'd212, 8'd184, 8'd116, 8'd45,  8'd138,
        8'd179, 8'd243, 8'd37,  8'd56,  8'd200, 8'd207, 8'd12,  8'd38,
        8'd204, 8'd186, 8'd159, 8'd34,  8'd213, 8'd192, 8'd41,  8'd0,
        8'd180, 8'd122, 8'd20,  8'd60,  8'd58,  8'd222, 8'd134, 8'd137,
        8'd241, 8'd112, 8'd182, 8'd169, 8'd92,  8'd26,  8'd219, 8'd24,
        8'd127, 8'd194, 8'd171, 8'd209, 8'd7,   8'd85,  8'd195, 8'd9,
        8'd65,  8'd226, 8'd43,  8'd248, 8'd83,  8'd211, 8'd202, 8'd190,
        8'd239, 8'd10,  8'd229, 8'd251, 8'd102, 8'd76,  8'd57,  8'd238,
        8'd89,  8'd105, 8'd101, 8'd187, 8'd177, 8'd131, 8'd123, 8'd225,
        8'd82,  8'd126, 8'd16,  8'd188, 8'd166, 8'd140, 8'd163, 8'd193,
        8'd49,  8'd48,  8'd36,  8'd18,  8'd53,  8'd81,  8'd146, 8'd252,
        8'd69,  8'd54,  8'd31,  8'd161, 8'd145, 8'd107, 8'd168, 8'd176,
        8'd46,  8'd125, 8'd124, 8'd223, 8'd230, 8'd214, 8'd151, 8'd133
    };

    // One message word waiting to be sent. gap_pct is the chance, in percent, that the
    // sender holds back on a given edge instead of offering it, so each word carries the idling
    // of the phase it belongs to.
    typedef struct {
        logic [63:0] word;
        logic        fresh;
        int          gap_pct;
    } message_word_t;

    // One digest word the block should emit.
    typedef struct {
        logic [63:0] word;
        logic [2:0]  num;
        logic        last;
    } digest_beat_t;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        start       = 1'b0;
    logic [63:0] block_word  = '0;
    logic        start_fresh = 1'b0;
    logic        busy;
    logic        done;
    logic [63:0] digest_word;
    logic [2:0]  word_number;
    logic        digest_last;

    message_word_t pending_words[$];
    digest_beat_t  digest_beats_due[$];

    // Our own copy of the block's state, advanced once per accepted beat.
    logic [7:0] digest_model [DIGEST_BYTES];
    logic [7:0] block_model  [DIGEST_BYTES];
    int         word_slot;

    int mismatches  = 0;
    int cycle_count = 0;

    treyfer_hash_compress dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .block_word  (block_word),
        .start_fresh (start_fresh),
        .done        (done),
        .digest_word (digest_word),
        .word_number (word_number),
        .digest_last (digest_last)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Folds one accepted word into the model. A fresh flag wipes the digest at once, even
    // in the middle of a block, without moving the word position. The eighth word runs the
    // serial mixing chain over the digest, XORs in the buffered block and queues the eight
    // digest words that the block must then emit back to back.
    task automatic absorb_word(input logic [63:0] word, input logic fresh);
        logic [7:0]   mix;
        int           idx;
        digest_beat_t beat;
        if (fresh)
        begin
            foreach (digest_model[i])
                digest_model[i] = 8'h00;
        end
        for (int k = 0; k < WORDS; k++)
            block_model[word_slot * WORDS + k] = word[8*k +: 8];
        if (word_slot != WORDS - 1)
        begin
            word_slot++;
        end
        else
        begin
            word_slot = 0;
            mix = digest_model[0];
            idx = 0;
            for (int s = 0; s < MIX_STEPS; s++)
            begin
                idx = (idx + 1) % DIGEST_BYTES;
                mix = MIX_SBOX[mix] + digest_model[idx];
                mix = {mix[6:0], mix[7]};
                digest_model[idx] = mix;
            end
            foreach (digest_model[i])
                digest_model[i] ^= block_model[i];
            for (int j = 0; j < WORDS; j++)
            begin
                for (int k = 0; k < WORDS; k++)
                    beat.word[8*k +: 8] = digest_model[j * WORDS + k];
                beat.num  = 3'(j);
                beat.last = (j == WORDS - 1);
                digest_beats_due.push_back(beat);
            end
        end
    endtask

    // Driver. A beat is taken at an edge where start is high and busy is low; that is the
    // moment the model is advanced. While the block is busy the offered word is held. When
    // nothing is offered, the data lines carry noise that the block must ignore. Each signal
    // gets exactly one assignment per edge, so start never dips between back-to-back beats.
    always @(posedge clk)
    begin : word_driver
        logic          hold;
        logic          offer;
        message_word_t nxt;
        if (rst_n)
        begin
            hold  = start && busy;
            offer = 1'b0;
            if (start && !busy)
                absorb_word(block_word, start_fresh);
            if (!hold && pending_words.size() != 0)
                offer = ($urandom_range(99) >= pending_words[0].gap_pct);
            if (offer)
            begin
                nxt = pending_words.pop_front();
                start       <= 1'b1;
                block_word  <= nxt.word;
                start_fresh <= nxt.fresh;
            end
            else if (!hold)
            begin
                start       <= 1'b0;
                block_word  <= {$urandom, $urandom};
                start_fresh <= 1'($urandom_range(1));
            end
        end
    end

    // Monitor. The block cannot be stalled, so every cycle with done high is a beat that
    // must match the oldest digest word still due, field by field.
    always @(posedge clk)
    begin : digest_monitor
        digest_beat_t want;
        if (rst_n && done)
        begin
            if (digest_beats_due.size() == 0)
            begin
                $display("%0t: digest beat with nothing due: word %h number %0d last %0b",
                         $realtime, digest_word, word_number, digest_last);
                mismatches++;
            end
            else
            begin
                want = digest_beats_due.pop_front();
                if (digest_word !== want.word)
                begin
                    $display("%0t: digest_word expected %h got %h", $realtime,
                             want.word, digest_word);
                    mismatches++;
                end
                if (word_number !== want.num)
                begin
                    $display("%0t: word_number expected %0d got %0d", $realtime,
                             want.num, word_number);
                    mismatches++;
                end
                if (digest_last !== want.last)
                begin
                    $display("%0t: digest_last expected %0b got %0b", $realtime,
                             want.last, digest_last);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d words unsent and %0d digest beats due",
                     $realtime, pending_words.size(), digest_beats_due.size());
            $display("** treyfer_hash_compress: FAILED **");
            $finish;
        end
    end

    task automatic add_word(input logic [63:0] word, input logic fresh, input int gap_pct);
        message_word_t item;
        item.word    = word;
        item.fresh   = fresh;
        item.gap_pct = gap_pct;
        pending_words.push_back(item);
    endtask

    // Random message words: mostly full-entropy, with whole words of zeros or ones now and
    // then so the adder and rotate see saturated bytes too.
    function automatic logic [63:0] pick_word();
        case ($urandom_range(9))
            0:       return 64'h0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial
    begin : stimulus
        logic [63:0] pattern [WORDS];
        int          idle_by_phase [4];
        int          gap;
        foreach (digest_model[i])
        begin
            digest_model[i] = 8'h00;
            block_model[i]  = 8'h00;
        end
        word_slot = 0;

        // Directed blocks, all with the sender never idle.
        // An all-zero block on a freshly cleared digest: the pure mixing chain on zeros.
        for (int w = 0; w < WORDS; w++)
            add_word(64'h0, w == 0, 0);
        // An all-ones block whose clear arrives on the last word itself, so the digest is
        // wiped right before the compression it starts.
        for (int w = 0; w < WORDS; w++)
            add_word('1, w == WORDS - 1, 0);
        // Walking and alternating patterns, with the clear arriving mid-block: the digest
        // is wiped but the block keeps its position.
        pattern = '{64'h1, 64'h8000_0000_0000_0000, 64'h5555_5555_5555_5555,
                    64'hAAAA_AAAA_AAAA_AAAA, 64'h0123_4567_89AB_CDEF,
                    64'hFEDC_BA98_7654_3210, 64'h00FF_00FF_00FF_00FF,
                    64'hFF00_FF00_FF00_FF00};
        for (int w = 0; w < WORDS; w++)
            add_word(pattern[w], w == 3, 0);

        // Random blocks in four idling phases: none, a sender that idles heavily, none
        // again, and a lightly idling sender. The receiver side has no back-pressure to
        // apply, so those phases only vary the sender. Most blocks chain onto the previous
        // digest; some restart from zero, and a few carry a stray clear on a later word.
        idle_by_phase = '{0, 87, 0, 13};
        for (int b = 0; b < RANDOM_BLOCKS; b++)
        begin
            gap = idle_by_phase[b / (RANDOM_BLOCKS / 4)];
            for (int w = 0; w < WORDS; w++)
            begin
                if (w == 0)
                    add_word(pick_word(), $urandom_range(3) == 0, gap);
                else
                    add_word(pick_word(), $urandom_range(19) == 0, gap);
            end
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Let every word go out and every digest beat come back, then give the block a
        // few more cycles in case it emits anything unexpected.
        while (pending_words.size() != 0 || start || digest_beats_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("** treyfer_hash_compress: PASSED **");
        else
            $display("** treyfer_hash_compress: FAILED **");
        $finish;
    end

endmodule
